// ----- hdl/fault_record_store_unit_assert.svh -----
// Assertion macros for the fault record store.
// Used by fault_record_store_unit.sv; no other dependencies.
`ifndef FAULT_RECORD_STORE_UNIT_ASSERT_SVH
`define FAULT_RECORD_STORE_UNIT_ASSERT_SVH
// Implication checked every clock edge outside reset.
`define FRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset.
`define FRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/frs_pkg.sv -----
// Package for the fault record store: sizes, command codes, record type.
// No dependencies.
`default_nettype none
package frs_pkg;
  localparam int unsigned Capacity = 128;
  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned RecW = 35;

  localparam logic [2:0] CmdSet = 3'd0;
  localparam logic [2:0] CmdGet = 3'd1;
  localparam logic [2:0] CmdRemove = 3'd2;
  localparam logic [2:0] CmdStart = 3'd3;
  localparam logic [2:0] CmdHandle = 3'd4;
  localparam logic [2:0] CmdClear = 3'd5;

  localparam logic CfgRetry = 1'b0;
  localparam logic CfgClear = 1'b1;

  typedef struct packed {
    logic [15:0] mod;
    logic [15:0] err;
    logic [2:0]  sev;
  } rec_t;
endpackage
`default_nettype wire

// ----- hdl/fault_record_store_unit.sv -----
// Fault record store top level: command sequencer over one record RAM.
// Depends on frs_pkg, frs_ram and fault_record_store_unit_assert.svh.
//
// channel | direction | words
// in      | input     | cmd, module_id, error_id, severity
// out     | output    | found, found_severity, store_full, record_count
// cfg     | input     | we, index, data (retry limit, clear severity limit)
//
// Set, engine start, clear, unused codes and a handle below the retry limit go
// straight from accept to the done state, where result valid rises. Get reads
// and checks records in order until a hit or the count; remove/handle read
// every record and overwrite each deleted one with the last record (read and
// write-back), all through the single RAM read port. No clearing pass: the
// count bounds every read. One command at a time; input stalls until the result
// is taken.
`default_nettype none
`include "fault_record_store_unit_assert.svh"
module fault_record_store_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [15:0] module_id_i,
  input  wire logic [15:0] error_id_i,
  input  wire logic [2:0]  severity_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             found_o,
  output logic [2:0]       found_severity_o,
  output logic             store_full_o,
  output logic [7:0]       record_count_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);
  localparam int unsigned AW = frs_pkg::AddrW;
  localparam int unsigned CW = frs_pkg::CntW;

  typedef enum logic [2:0] {
    StIdle, StRead, StCheck, StLastRd, StLastWr, StDone
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q, idx_q;
  logic [31:0] starts_q;
  logic [7:0] retry_q;
  logic [2:0] clr_lim_q;
  logic [2:0] cmd_q, lim_q;
  logic [15:0] mod_q, err_q;
  logic found_q, full_q;
  logic [2:0] fsev_q;

  logic we;
  logic [AW-1:0] waddr, raddr;
  frs_pkg::rec_t wdata, rdata;

  frs_ram #(.Width(frs_pkg::RecW), .Depth(frs_pkg::Capacity)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // RAM port steering per state; in StLastWr the read data is the last record
  always_comb begin
    we = 1'b0;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    raddr = idx_q[AW-1:0];
    case (state_q)
      StIdle: begin
        we = in_valid_i && !in_stall_o && cmd_i == frs_pkg::CmdSet
             && count_q < CW'(frs_pkg::Capacity);
        waddr = count_q[AW-1:0];
        wdata = '{mod: module_id_i, err: error_id_i, sev: severity_i};
      end
      StLastRd: raddr = AW'(count_q - 1'b1);
      StLastWr: we = 1'b1;
      default: ;
    endcase
  end

  assign in_stall_o = state_q != StIdle;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_q <= 8'd3;
      clr_lim_q <= 3'd2;
    end else if (cfg_we_i) begin
      if (cfg_index_i == frs_pkg::CfgRetry) retry_q <= cfg_data_i;
      else clr_lim_q <= cfg_data_i[2:0];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      starts_q <= '0;
      out_valid_o <= 1'b0;
      idx_q <= '0;
    end else begin
      case (state_q)
        StIdle: if (in_valid_i) begin
          cmd_q <= cmd_i; mod_q <= module_id_i; err_q <= error_id_i;
          found_q <= 1'b0; fsev_q <= '0; full_q <= 1'b0; idx_q <= '0;
          state_q <= StDone;
          case (cmd_i)
            frs_pkg::CmdSet:
              if (count_q < CW'(frs_pkg::Capacity)) count_q <= count_q + 1'b1;
              else full_q <= 1'b1;
            frs_pkg::CmdGet: state_q <= StRead;
            frs_pkg::CmdRemove: begin
              lim_q <= severity_i; state_q <= StRead;
            end
            frs_pkg::CmdStart: if (starts_q != '1) starts_q <= starts_q + 1'b1;
            frs_pkg::CmdHandle: if (starts_q >= {24'd0, retry_q}) begin
              lim_q <= clr_lim_q; state_q <= StRead;
            end
            frs_pkg::CmdClear: begin
              count_q <= '0; starts_q <= '0;
            end
            default: ;
          endcase
        end
        StRead: state_q <= (idx_q < count_q) ? StCheck : StDone;
        StCheck: begin
          if (cmd_q == frs_pkg::CmdGet) begin
            if (rdata.mod == mod_q && rdata.err == err_q) begin
              found_q <= 1'b1; fsev_q <= rdata.sev; state_q <= StDone;
            end else begin
              idx_q <= idx_q + 1'b1; state_q <= StRead;
            end
          end else if (rdata.sev <= lim_q) begin
            state_q <= StLastRd;
          end else begin
            idx_q <= idx_q + 1'b1; state_q <= StRead;
          end
        end
        StLastRd: state_q <= StLastWr;
        StLastWr: begin
          // last record moves into the freed slot; recheck same slot
          count_q <= count_q - 1'b1;
          state_q <= StRead;
        end
        StDone: begin
          if (!out_valid_o) out_valid_o <= 1'b1;
          else if (!out_stall_i) begin
            out_valid_o <= 1'b0; state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign found_o = found_q;
  assign found_severity_o = fsev_q;
  assign store_full_o = full_q;
  assign record_count_o = 8'(count_q);

  `FRS_ASSERT_IMP(a_cnt_cap, 1'b1, count_q <= CW'(frs_pkg::Capacity),
    "count exceeds capacity")
  `FRS_ASSERT_IMP(a_out_done, out_valid_o, state_q == StDone,
    "result valid outside done")
  `FRS_ASSERT_NEXT(a_full_noinc, state_q == StIdle && in_valid_i && cmd_i == frs_pkg::CmdSet
    && count_q == CW'(frs_pkg::Capacity), full_q, "full set not flagged")
endmodule
`default_nettype wire

// ----- hdl/frs_ram.sv -----
// Generic single-port-write, one-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module frs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- bench/fault_record_store_checker.sv -----
// Checker for the fault record store: watches the command and result channels,
// predicts each result from its own copy of the store and compares. Uses frs_pkg.
`timescale 1ns / 100ps
module fault_record_store_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [15:0] module_id_i,
  input  wire logic [15:0] error_id_i,
  input  wire logic [2:0]  severity_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic        found_i,
  input  wire logic [2:0]  found_severity_i,
  input  wire logic        store_full_i,
  input  wire logic [7:0]  record_count_i,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  typedef struct packed {
    logic       found;
    logic [2:0] fsev;
    logic       full;
    logic [7:0] cnt;
  } outcome_t;

  frs_pkg::rec_t shadow_recs[frs_pkg::Capacity];
  int unsigned shadow_cnt;
  logic [31:0] starts;
  logic [7:0]  retry_lim;
  logic [2:0]  clear_lim;
  outcome_t    outcome_q[$];

  assign pending_o = outcome_q.size();

  // delete records at or below limit, moving the last one into the hole
  task automatic purge_upto(input logic [2:0] limit);
    int unsigned i;
    i = 0;
    while (i < shadow_cnt) begin
      if (shadow_recs[i].sev <= limit) begin
        shadow_recs[i] = shadow_recs[shadow_cnt - 1];
        shadow_cnt--;
      end else begin
        i++;
      end
    end
  endtask

  task automatic predict_outcome(input logic [2:0] cmd, input logic [15:0] m,
                                 input logic [15:0] e, input logic [2:0] s);
    outcome_t o;
    o = '0;
    case (cmd)
      frs_pkg::CmdSet: begin
        if (shadow_cnt < frs_pkg::Capacity) begin
          shadow_recs[shadow_cnt] = '{mod: m, err: e, sev: s};
          shadow_cnt++;
        end else o.full = 1'b1;
      end
      frs_pkg::CmdGet: begin
        for (int i = 0; i < shadow_cnt; i++) begin
          if (shadow_recs[i].mod == m && shadow_recs[i].err == e) begin
            o.found = 1'b1;
            o.fsev = shadow_recs[i].sev;
            break;
          end
        end
      end
      frs_pkg::CmdRemove: purge_upto(s);
      frs_pkg::CmdStart: if (starts != 32'hFFFF_FFFF) starts++;
      frs_pkg::CmdHandle: if (starts >= {24'd0, retry_lim}) purge_upto(clear_lim);
      frs_pkg::CmdClear: begin
        shadow_cnt = 0;
        starts = '0;
      end
      default: ;
    endcase
    o.cnt = shadow_cnt[7:0];
    outcome_q.push_back(o);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t x;
    if (!rst_ni) begin
      shadow_cnt = 0;
      starts = '0;
      retry_lim = 8'd3;
      clear_lim = 3'd2;
      outcome_q.delete();
      fail_count_o = 0;
    end else begin
      // result side first: a result never belongs to a command of this edge
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          $error("result word with no expectation");
          fail_count_o++;
        end else begin
          x = outcome_q.pop_front();
          if (found_i !== x.found) begin
            $error("found exp %0d got %0d", x.found, found_i);
            fail_count_o++;
          end
          if (found_severity_i !== x.fsev) begin
            $error("found_severity exp %0d got %0d", x.fsev, found_severity_i);
            fail_count_o++;
          end
          if (store_full_i !== x.full) begin
            $error("store_full exp %0d got %0d", x.full, store_full_i);
            fail_count_o++;
          end
          if (record_count_i !== x.cnt) begin
            $error("record_count exp %0d got %0d", x.cnt, record_count_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == frs_pkg::CfgRetry) retry_lim = cfg_data_i;
        else clear_lim = cfg_data_i[2:0];
      end
      if (in_valid_i && !in_stall_i)
        predict_outcome(cmd_i, module_id_i, error_id_i, severity_i);
    end
  end
endmodule

// ----- bench/testbench.sv -----
// Testbench top: drives commands and register writes into the fault record
// store and gives the verdict. Depends on frs_pkg and fault_record_store_checker.
`timescale 1ns / 100ps
module testbench;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall, out_valid, out_stall = 1'b0;
  logic [2:0]  cmd = '0;
  logic [15:0] module_id = '0, error_id = '0;
  logic [2:0]  severity = '0;
  logic        found, store_full;
  logic [2:0]  found_severity;
  logic [7:0]  record_count;
  logic        cfg_we = 1'b0, cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;
  int          fail_count, pending;
  logic [15:0] key_mods[8], key_errs[8];

  always #6 clk_i = ~clk_i;

  fault_record_store_unit u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .module_id_i(module_id), .error_id_i(error_id),
    .severity_i(severity),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .found_o(found), .found_severity_o(found_severity),
    .store_full_o(store_full), .record_count_o(record_count),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  fault_record_store_checker u_chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .module_id_i(module_id), .error_id_i(error_id),
    .severity_i(severity),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .found_i(found), .found_severity_i(found_severity),
    .store_full_i(store_full), .record_count_i(record_count),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall per word
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) w = 0;
      out_stall <= (w != 0);
      repeat (w) @(posedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // valid drops only ahead of an idle gap; drain drops it after the last word
  task automatic send_word(input logic [2:0] c, input logic [15:0] m,
                           input logic [15:0] e, input logic [2:0] s);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cmd <= c;
    module_id <= m;
    error_id <= e;
    severity <= s;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4 * frs_pkg::Capacity + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly well-formed traffic reusing a few keys so gets hit
  task automatic random_word();
    int k, r;
    logic [2:0] c;
    k = $urandom_range(0, 7);
    r = $urandom_range(0, 99);
    if (r < 40) c = frs_pkg::CmdSet;
    else if (r < 65) c = frs_pkg::CmdGet;
    else if (r < 73) c = frs_pkg::CmdRemove;
    else if (r < 85) c = frs_pkg::CmdStart;
    else if (r < 94) c = frs_pkg::CmdHandle;
    else if (r < 97) c = frs_pkg::CmdClear;
    else c = 3'($urandom_range(6, 7));
    if ($urandom_range(0, 4) == 0)
      send_word(c, 16'($urandom), 16'($urandom), 3'($urandom));
    else
      send_word(c, key_mods[k], key_errs[k],
                ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 4)));
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      key_mods[i] = 16'($urandom);
      key_errs[i] = 16'($urandom);
    end
    key_mods[0] = 16'hFFFF; key_errs[0] = 16'hFFFF;
    key_mods[1] = 16'h0000; key_errs[1] = 16'h0000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty-store ops, extremes, odd severities, unused codes
    send_word(frs_pkg::CmdRemove, 16'h0, 16'h0, 3'd4);
    send_word(frs_pkg::CmdHandle, 16'h0, 16'h0, 3'd0);
    send_word(frs_pkg::CmdGet, 16'hFFFF, 16'hFFFF, 3'd0);
    send_word(frs_pkg::CmdSet, 16'hFFFF, 16'hFFFF, 3'd7);
    send_word(frs_pkg::CmdSet, 16'h0000, 16'h0000, 3'd0);
    send_word(frs_pkg::CmdSet, 16'hA5A5, 16'h5A5A, 3'd4);
    send_word(frs_pkg::CmdSet, 16'hFFFF, 16'hFFFF, 3'd1);
    send_word(frs_pkg::CmdGet, 16'hFFFF, 16'hFFFF, 3'd0);
    send_word(frs_pkg::CmdGet, 16'h0000, 16'h0000, 3'd7);
    send_word(frs_pkg::CmdGet, 16'h1234, 16'h0000, 3'd0);
    send_word(3'd6, 16'h0, 16'h0, 3'd0);
    send_word(3'd7, 16'hFFFF, 16'hFFFF, 3'd7);
    send_word(frs_pkg::CmdRemove, 16'h0, 16'h0, 3'd0);
    send_word(frs_pkg::CmdHandle, 16'h0, 16'h0, 3'd0);
    repeat (3) send_word(frs_pkg::CmdStart, 16'h0, 16'h0, 3'd0);
    send_word(frs_pkg::CmdHandle, 16'h0, 16'h0, 3'd0);
    send_word(frs_pkg::CmdRemove, 16'h0, 16'h0, 3'd5);
    send_word(frs_pkg::CmdClear, 16'h0, 16'h0, 3'd0);
    // fill to full and one past
    for (int i = 0; i <= frs_pkg::Capacity; i++)
      send_word(frs_pkg::CmdSet, 16'(i), 16'($urandom), 3'($urandom_range(0, 4)));
    send_word(frs_pkg::CmdHandle, 16'h0, 16'h0, 3'd0);
    send_word(frs_pkg::CmdRemove, 16'h0, 16'h0, 3'd3);
    // hold off until every result is back
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(frs_pkg::CfgRetry, 8'd0); write_reg(frs_pkg::CfgClear, 8'd0);
        end
        1: begin
          write_reg(frs_pkg::CfgRetry, 8'd255); write_reg(frs_pkg::CfgClear, 8'd4);
        end
        2: begin
          write_reg(frs_pkg::CfgRetry, 8'd1); write_reg(frs_pkg::CfgClear, 8'd7);
        end
        default: begin
          write_reg(frs_pkg::CfgRetry, 8'($urandom_range(0, 8)));
          write_reg(frs_pkg::CfgClear, 8'($urandom_range(0, 7)));
        end
      endcase
      for (int n = 0; n < 75; n++) random_word();
      drain();
    end

    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
